@@ rtl/fpmk_pkg.sv @@
package fpmk_pkg;

  localparam int TIME_W  = 32;
  localparam int WORK_W  = 16;
  localparam int SLOT_W  = 3;
  localparam int MASK_W  = 8;
  localparam int LIMIT_W = 2;

  // Misses tolerated per window after reset.
  localparam logic [LIMIT_W-1:0] MISS_LIMIT_RST = 2'd1;

  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_LOAD = 1'b1
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [SLOT_W-1:0]   task_slot;
    logic [WORK_W-1:0]   exec_time;
    logic [WORK_W-1:0]   task_period;
    logic [WORK_W-1:0]   rel_deadline;
    logic [TIME_W-1:0]   first_release;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0]   tick_time;
    logic                busy_res;
    logic [SLOT_W-1:0]   granted_task;
    logic                job_done;
    logic                missed;
    logic                task_violated;
    logic [MASK_W-1:0]   violation_mask;
  } out_item_t;

endpackage

@@ rtl/fpmk_if.sv @@
interface fpmk_in_if;
  import fpmk_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface fpmk_out_if;
  import fpmk_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/fixed_priority_mk_firm_scheduler.sv @@
// Fixed-priority task scheduler with (m,k)-firm deadline monitoring.
//
// Beats arrive on the items channel. A load beat writes one periodic task
// into the table at task_slot (lower slot means higher priority); a tick
// beat grants one time unit to the highest-priority released task that
// still has work, and then advances the tick counter. Every beat, load or
// tick, produces exactly one beat on the results channel.
//
// The result beat is valid in the cycle after the input beat is accepted, and
// one beat per cycle is taken while the receiver does not stall, set by the
// single pass through the priority pick, the deadline check and the window
// count between the table registers and the result register.
//
// The user must write the miss limit via cfg_we and cfg_data only while the
// block is idle; the block does not enforce it. Reset (synchronous, active
// high) clears the tick counter, all table valid and violation flags, empties
// the result register and sets the miss limit to one. While the receiver
// stalls, the result beat is held in the result register and items.ready
// stays low, so no input beat is taken until the held result is taken.
module fixed_priority_mk_firm_scheduler #(
  parameter int TASKS  = 8,
  parameter int WINDOW = 3
) (
  input  logic                         clk,
  input  logic                         rst,
  fpmk_in_if.sink                      items,
  fpmk_out_if.source                   results,
  input  logic                         cfg_we,
  input  logic [fpmk_pkg::LIMIT_W-1:0] cfg_data
);
  import fpmk_pkg::*;

  localparam int TIDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

  // Control state.
  logic [TIME_W-1:0]  now;
  logic [TASKS-1:0]   entry_valid;
  logic [TASKS-1:0]   violated;
  logic [LIMIT_W-1:0] miss_limit;
  logic               out_valid;

  // Task table payload; every entry is written by a load before it is used.
  logic [WORK_W-1:0] wcet_store     [TASKS];
  logic [WORK_W-1:0] period_store   [TASKS];
  logic [WORK_W-1:0] remaining_work [TASKS];
  logic [TIME_W-1:0] release_time   [TASKS];
  logic [TIME_W-1:0] abs_deadline   [TASKS];
  logic [POS_W-1:0]  window_pos     [TASKS];
  logic [WINDOW-1:0] miss_window    [TASKS];

  out_item_t out_data;

  logic              accept;
  logic              is_load;
  logic              is_tick;
  logic [TASKS-1:0]  task_ready;
  logic [TASKS-1:0]  wr_sel;
  logic [TIDX_W-1:0] grant_idx;
  logic              grant;
  logic [WORK_W-1:0] rem_left;
  logic              done;
  logic              late;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  pos_next;
  logic [WINDOW-1:0] win_new;
  logic [CNT_W-1:0]  miss_cnt;
  logic              over_limit;
  logic [TASKS-1:0]  violated_next;
  logic [MASK_W-1:0] mask_bits;
  out_item_t         out_data_next;

  // The result register frees its slot when its beat is taken, so a new
  // beat can enter in the same cycle.
  assign items.ready     = !rst && (!out_valid || results.ready);
  assign accept          = items.valid && items.ready;
  assign is_load         = accept && (items.payload.action == ACT_LOAD);
  assign is_tick         = accept && (items.payload.action == ACT_TICK);
  assign results.valid   = out_valid;
  assign results.payload = out_data;

  // A task is runnable once loaded, released and with work left. Slots
  // outside the table never match, so such loads are dropped.
  always_comb begin
    for (int i = 0; i < TASKS; i++) begin
      task_ready[i] = entry_valid[i] && (remaining_work[i] != '0) &&
                      (release_time[i] <= now);
      wr_sel[i]     = is_load && (int'(items.payload.task_slot) == i);
    end
  end

  // Priority encoder: the lowest runnable index wins.
  always_comb begin
    grant_idx = '0;
    for (int i = TASKS - 1; i >= 0; i--) begin
      if (task_ready[i]) begin
        grant_idx = TIDX_W'(i);
      end
    end
  end

  assign grant    = is_tick && (|task_ready);
  assign rem_left = remaining_work[grant_idx] - WORK_W'(1);
  assign done     = (rem_left == '0);
  assign late     = now > abs_deadline[grant_idx];
  assign pos      = window_pos[grant_idx];
  assign pos_next = (pos == POS_LAST) ? '0 : pos + POS_W'(1);

  // The finished job overwrites the oldest slot of the ring window.
  always_comb begin
    win_new      = miss_window[grant_idx];
    win_new[pos] = late;
  end

  assign miss_cnt   = CNT_W'($countones(win_new));
  assign over_limit = CMP_W'(miss_cnt) > CMP_W'(miss_limit);

  // A reload clears the flag; a finished job over the limit sets it.
  always_comb begin
    violated_next = violated;
    for (int i = 0; i < TASKS; i++) begin
      if (wr_sel[i]) begin
        violated_next[i] = 1'b0;
      end
    end
    if (grant && done && over_limit) begin
      violated_next[grant_idx] = 1'b1;
    end
  end

  for (genvar b = 0; b < MASK_W; b++) begin : g_mask
    if (b < TASKS) begin : g_bit
      assign mask_bits[b] = violated_next[b];
    end else begin : g_pad
      assign mask_bits[b] = 1'b0;
    end
  end

  always_comb begin
    out_data_next.tick_time      = now;
    out_data_next.busy_res       = grant;
    out_data_next.granted_task   = grant ? SLOT_W'(grant_idx) : '0;
    out_data_next.job_done       = grant && done;
    out_data_next.missed         = grant && done && late;
    out_data_next.task_violated  = grant && violated_next[grant_idx];
    out_data_next.violation_mask = mask_bits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now         <= '0;
      entry_valid <= '0;
      violated    <= '0;
      miss_limit  <= MISS_LIMIT_RST;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        miss_limit <= cfg_data;
      end
      if (is_tick) begin
        now <= now + TIME_W'(1);
      end
      entry_valid <= entry_valid | wr_sel;
      violated    <= violated_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= out_data_next;
    end
  end

  // Table update: a load restarts the entry; the granted task burns one
  // unit and, when its job completes, re-arms one period later.
  always_ff @(posedge clk) begin
    for (int i = 0; i < TASKS; i++) begin
      if (wr_sel[i]) begin
        wcet_store[i]     <= items.payload.exec_time;
        period_store[i]   <= items.payload.task_period;
        remaining_work[i] <= items.payload.exec_time;
        release_time[i]   <= items.payload.first_release;
        abs_deadline[i]   <= items.payload.first_release +
                             TIME_W'(items.payload.rel_deadline);
        window_pos[i]     <= '0;
        miss_window[i]    <= '0;
      end else if (grant && (grant_idx == TIDX_W'(i))) begin
        if (done) begin
          remaining_work[i] <= wcet_store[i];
          release_time[i]   <= release_time[i] + TIME_W'(period_store[i]);
          abs_deadline[i]   <= abs_deadline[i] + TIME_W'(period_store[i]);
          window_pos[i]     <= pos_next;
          miss_window[i]    <= win_new;
        end else begin
          remaining_work[i] <= rem_left;
        end
      end
    end
  end

endmodule

@@ rtl/fpmk_checker.sv @@
module fpmk_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input fpmk_pkg::out_item_t out_data
);
  import fpmk_pkg::*;

  // A result beat that is not taken stays put with its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Every accepted item shows up as a result beat in the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result beat");

  // An idle tick or a load reports no task activity.
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.busy_res |->
      out_data.granted_task == '0 && !out_data.job_done &&
      !out_data.missed && !out_data.task_violated)
    else $error("idle result carries task fields");

  // A miss can only be reported for a job that finished on a busy tick.
  a_miss_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.missed |-> out_data.job_done && out_data.busy_res)
    else $error("miss reported without a finished job");

  // The granted task's flag agrees with its bit in the mask.
  a_flag_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.task_violated |->
      out_data.violation_mask[out_data.granted_task])
    else $error("task flag missing from violation mask");

endmodule

bind fixed_priority_mk_firm_scheduler fpmk_checker u_fpmk_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (items.valid),
  .in_ready  (items.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_data  (results.payload)
);

@@ test/fpmk_sched_checker.sv @@
// Watches both channels and the miss limit port. It keeps its own copy of the
// scheduler state, works out the result beat for every accepted input beat,
// and compares each accepted result beat with the oldest one owed.
module fpmk_sched_checker
  import fpmk_pkg::*;
#(
  parameter int TASKS  = 8,
  parameter int WINDOW = 3
) (
  input  logic               clk,
  input  logic               rst,
  fpmk_in_if                 items,
  fpmk_out_if                results,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_data,
  output int                 mismatch_count,
  output int                 results_owed
);

  logic [LIMIT_W-1:0] miss_limit_q;
  logic [TIME_W-1:0]  now_tick;
  bit                 loaded     [TASKS];
  logic [WORK_W-1:0]  wcet       [TASKS];
  logic [WORK_W-1:0]  period     [TASKS];
  logic [WORK_W-1:0]  work_left  [TASKS];
  logic [TIME_W-1:0]  release_at [TASKS];
  logic [TIME_W-1:0]  deadline_at[TASKS];
  logic [WINDOW-1:0]  miss_win   [TASKS];
  int unsigned        win_pos    [TASKS];
  bit                 flagged    [TASKS];

  out_item_t owed_q[$];
  int        errs = 0;

  assign mismatch_count = errs;

  // Applies one input beat to the table and returns the result beat it gives.
  function automatic out_item_t schedule_beat(in_item_t beat);
    out_item_t   res;
    int          pick;
    int          s;
    int          i;
    int unsigned pos;
    bit          late;
    res = '0;
    res.tick_time = now_tick;
    pick = -1;
    if (beat.action == ACT_LOAD) begin
      s = int'(beat.task_slot);
      if (s < TASKS) begin
        loaded[s]      = 1'b1;
        wcet[s]        = beat.exec_time;
        period[s]      = beat.task_period;
        work_left[s]   = beat.exec_time;
        release_at[s]  = beat.first_release;
        deadline_at[s] = beat.first_release + TIME_W'(beat.rel_deadline);
        win_pos[s]     = 0;
        miss_win[s]    = '0;
        flagged[s]     = 1'b0;
      end
    end else begin
      for (i = 0; i < TASKS; i++) begin
        if (pick < 0 && loaded[i] && work_left[i] != '0 && release_at[i] <= now_tick) begin
          pick = i;
        end
      end
      if (pick >= 0) begin
        res.busy_res     = 1'b1;
        res.granted_task = SLOT_W'(pick);
        work_left[pick]  = work_left[pick] - 1'b1;
        if (work_left[pick] == '0) begin
          pos  = win_pos[pick] % WINDOW;
          late = now_tick > deadline_at[pick];
          res.job_done = 1'b1;
          res.missed   = late;
          miss_win[pick][pos] = late;
          win_pos[pick] = (pos + 1) % WINDOW;
          if ($countones(miss_win[pick]) > int'(miss_limit_q)) begin
            flagged[pick] = 1'b1;
          end
          release_at[pick]  = release_at[pick] + TIME_W'(period[pick]);
          deadline_at[pick] = deadline_at[pick] + TIME_W'(period[pick]);
          work_left[pick]   = wcet[pick];
        end
        res.task_violated = flagged[pick];
      end
      now_tick = now_tick + 1'b1;
    end
    for (i = 0; i < TASKS && i < MASK_W; i++) begin
      res.violation_mask[i] = flagged[i];
    end
    return res;
  endfunction

  function automatic string show(out_item_t r);
    return $sformatf("t=%0d busy=%b task=%0d done=%b miss=%b viol=%b mask=%h",
                     r.tick_time, r.busy_res, r.granted_task, r.job_done, r.missed,
                     r.task_violated, r.violation_mask);
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    string     bad;
    if (rst) begin
      miss_limit_q = MISS_LIMIT_RST;
      now_tick     = '0;
      for (int i = 0; i < TASKS; i++) begin
        loaded[i]  = 1'b0;
        flagged[i] = 1'b0;
      end
      owed_q.delete();
    end else begin
      if (cfg_we) begin
        miss_limit_q = cfg_data;
      end
      if (items.valid && items.ready) begin
        owed_q.push_back(schedule_beat(items.payload));
      end
      if (results.valid && results.ready) begin
        if (owed_q.size() == 0) begin
          errs++;
          if (errs <= 10) begin
            $display("unexpected result beat: %s", show(results.payload));
          end
        end else begin
          want = owed_q.pop_front();
          bad  = "";
          if (results.payload.tick_time !== want.tick_time) bad = {bad, " tick_time"};
          if (results.payload.busy_res !== want.busy_res) bad = {bad, " busy_res"};
          if (results.payload.granted_task !== want.granted_task) bad = {bad, " granted_task"};
          if (results.payload.job_done !== want.job_done) bad = {bad, " job_done"};
          if (results.payload.missed !== want.missed) bad = {bad, " missed"};
          if (results.payload.task_violated !== want.task_violated) bad = {bad, " task_violated"};
          if (results.payload.violation_mask !== want.violation_mask) bad = {bad, " violation_mask"};
          if (bad != "") begin
            errs++;
            if (errs <= 10) begin
              $display("result mismatch in%s", bad);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(results.payload));
            end
          end
        end
      end
    end
    results_owed <= owed_q.size();
  end

endmodule

@@ test/tb_fixed_priority_mk_firm_scheduler.sv @@
// Top of the scheduler testbench. It only makes stimulus and gives the
// verdict; the checker beside the block predicts and compares every beat.
module tb_fixed_priority_mk_firm_scheduler;
  import fpmk_pkg::*;

  // Cycles with no beat moving on either channel before the run is called hung.
  localparam int STALL_LIMIT = 4000;
  // Input beats per random phase; four phases plus the directed part.
  localparam int PHASE_BEATS = 205;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_data;
  int                 mismatch_count;
  int                 results_owed;

  // While calm is set neither side idles, which gives one long stretch of
  // back-to-back beats.
  bit calm = 1'b0;
  // The block's tick counter only moves on tick beats, so counting them here
  // lets new tasks be released close to the current time.
  int ticks_sent = 0;
  int beats_sent = 0;
  int quiet_cycles = 0;

  fpmk_in_if  items_if();
  fpmk_out_if results_if();

  fixed_priority_mk_firm_scheduler dut (
    .clk      (clk),
    .rst      (rst),
    .items    (items_if),
    .results  (results_if),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  fpmk_sched_checker sched_chk (
    .clk            (clk),
    .rst            (rst),
    .items          (items_if),
    .results        (results_if),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The receiver stalls with a chance of about 13 in a hundred unless calm is set.
  always @(posedge clk) begin
    results_if.ready <= calm || ($urandom_range(99) >= 13);
  end

  // Watchdog: any beat on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (items_if.valid && items_if.ready) ||
        (results_if.valid && results_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_fixed_priority_mk_firm_scheduler failed");
      $finish;
    end
  end

  // Offers one beat, with random idle cycles ahead of it, and returns at the
  // clock edge at which the block takes it. Ready is looked at in the middle
  // of the cycle, so it is the value that the coming edge acts on. Valid is
  // left high so that the next beat can follow without a gap.
  task automatic send_beat(input in_item_t beat);
    while (!calm && $urandom_range(99) < 13) begin
      items_if.valid <= 1'b0;
      @(posedge clk);
    end
    items_if.valid   <= 1'b1;
    items_if.payload <= beat;
    @(negedge clk);
    while (!items_if.ready) @(negedge clk);
    @(posedge clk);
    beats_sent++;
    if (beat.action == ACT_TICK) ticks_sent++;
  endtask

  // Tick beats carry random junk in the unused fields; the block must ignore it.
  task automatic run_ticks(input int n);
    in_item_t beat;
    repeat (n) begin
      beat.action        = ACT_TICK;
      beat.task_slot     = SLOT_W'($urandom);
      beat.exec_time     = WORK_W'($urandom);
      beat.task_period   = WORK_W'($urandom);
      beat.rel_deadline  = WORK_W'($urandom);
      beat.first_release = $urandom;
      send_beat(beat);
    end
  endtask

  task automatic load_task(input logic [SLOT_W-1:0] slot, input logic [WORK_W-1:0] exec,
                           input logic [WORK_W-1:0] per, input logic [WORK_W-1:0] dl,
                           input logic [TIME_W-1:0] rel_tick);
    in_item_t beat;
    beat.action        = ACT_LOAD;
    beat.task_slot     = slot;
    beat.exec_time     = exec;
    beat.task_period   = per;
    beat.rel_deadline  = dl;
    beat.first_release = rel_tick;
    send_beat(beat);
  endtask

  // A short periodic task released within a few ticks of now. Random sets of
  // these often overload the table, so lower-priority tasks miss deadlines
  // and their windows fill up.
  task automatic load_short_task();
    int per;
    per = $urandom_range(14, 1);
    load_task(SLOT_W'($urandom), WORK_W'($urandom_range(4, 1)), WORK_W'(per),
              WORK_W'($urandom_range(per + 3, 1)),
              TIME_W'(ticks_sent + $urandom_range(6, 0)));
  endtask

  // Drops valid and waits until every owed result beat has come back.
  task automatic drain();
    items_if.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_miss_limit(input logic [LIMIT_W-1:0] limit);
    drain();
    cfg_data <= limit;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    logic [LIMIT_W-1:0] phase_limit [4];
    int                 target;
    int                 roll;
    phase_limit = '{2'd3, 2'd0, 2'd2, 2'd1};

    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_data         <= '0;
    items_if.valid   <= 1'b0;
    items_if.payload <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, under the miss limit of one that reset leaves.
    // A tick on an empty table gives an idle result.
    run_ticks(1);
    // A task with no execution time is loaded but never becomes ready.
    load_task(3'd7, 16'd0, 16'd3, 16'd3, 32'd0);
    run_ticks(1);
    // All-ones fields at the highest priority: released only at the last
    // tick of the time range, so it never runs here.
    load_task(3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    // A task with zero period re-arms at the same release and deadline, so
    // every later job is late and the task soon becomes violated.
    load_task(3'd4, 16'd2, 16'd0, 16'd1, 32'd0);
    run_ticks(4);
    // A higher-priority task released a little later preempts it.
    load_task(3'd2, 16'd1, 16'd4, 16'd4, TIME_W'(ticks_sent + 1));
    run_ticks(3);
    // Reloading the violated slot starts it fresh and clears its flag.
    load_task(3'd4, 16'd1, 16'd3, 16'd2, TIME_W'(ticks_sent + 1));
    // Low-priority filler with the smallest period and largest deadline.
    load_task(3'd5, 16'd1, 16'd1, 16'hFFFF, 32'd0);
    run_ticks(8);

    // Random phases, each under its own miss limit; the extremes come first.
    for (int p = 0; p < 4; p++) begin
      write_miss_limit(phase_limit[p]);
      calm   = (p == 1);
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) begin
        roll = $urandom_range(99);
        if (roll < 10) begin
          // Noise: a load with every field random, usually released far in
          // the future.
          load_task(SLOT_W'($urandom), WORK_W'($urandom), WORK_W'($urandom),
                    WORK_W'($urandom), $urandom);
        end else if (roll < 20) begin
          load_short_task();
          run_ticks($urandom_range(6, 1));
        end else begin
          // A fresh task set, then a stretch of time for it to run.
          repeat ($urandom_range(4, 1)) load_short_task();
          run_ticks($urandom_range(40, 8));
        end
      end
    end
    calm = 1'b0;

    drain();
    if (mismatch_count == 0) begin
      $display("tb_fixed_priority_mk_firm_scheduler passed");
    end else begin
      $display("tb_fixed_priority_mk_firm_scheduler failed");
    end
    $finish;
  end

endmodule

@@ fixed_priority_mk_firm_scheduler.f @@
rtl/fpmk_pkg.sv
rtl/fpmk_if.sv
rtl/fixed_priority_mk_firm_scheduler.sv
rtl/fpmk_checker.sv
test/fpmk_sched_checker.sv
test/tb_fixed_priority_mk_firm_scheduler.sv
